FILE: rtl/swer_pkg.sv
// Shared types, codes and constants of the sliding-window event rate unit.
package swer_pkg;

  // Field widths of the channels.
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_OUT_W = 7;

  // Default ring depth and register reset value.
  localparam int unsigned DEFAULT_RING_DEPTH = 64;
  localparam logic [DATA_W-1:0] PEAK_WINDOW_RESET = 32'd600000;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // latch the input transaction, clear accumulators
    logic exec_clear;   // empty the ring and zero the counters
    logic exec_record;  // store the stamp and update the counters
    logic scan_clr;     // restart the scan address
    logic scan_rd;      // read the ring at the scan address and step it
    logic trunc_rd;     // read the oldest stamp for the truncation check
    logic emit;         // load the result into the output register
  } swer_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ring_empty;
    logic              scan_last;
    logic              trunc_possible;
    logic              out_busy;
  } swer_status_t;

endpackage

FILE: rtl/swer_if.sv
// Channel interfaces of the sliding-window event rate unit.
interface swer_in_if import swer_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] time_ms;
  logic [DATA_W-1:0] query_window_ms;

  modport source (output valid, func, time_ms, query_window_ms, input ready);
  modport sink (input valid, func, time_ms, query_window_ms, output ready);
endinterface

interface swer_out_if import swer_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] window_count;
  logic                 window_truncated;
  logic [CNT_OUT_W-1:0] peak_count;
  logic [DATA_W-1:0]    peak_time_ms;
  logic [DATA_W-1:0]    total_records;
  logic [DATA_W-1:0]    discarded_records;
  logic [CNT_OUT_W-1:0] retained_records;

  modport source (
    output valid, window_count, window_truncated, peak_count, peak_time_ms,
           total_records, discarded_records, retained_records,
    input  ready
  );
  modport sink (
    input  valid, window_count, window_truncated, peak_count, peak_time_ms,
           total_records, discarded_records, retained_records,
    output ready
  );
endinterface

interface swer_cfg_if import swer_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/sliding_window_event_rate_unit.sv
// Sliding-window event rate unit: top level joining controller and datapath.
//
// Use: transactions enter on in_i (func, time_ms, query_window_ms) and each
// gives exactly one result transaction on out_o. func selects clear, record
// or query. The peak window register is written on cfg_i, which is always
// ready; write it only while no transaction is in progress.
// Sequence: the block works on one transaction at a time. A record scans
// every stamp held in the ring after its update; a query scans every stamp
// held and then makes the truncation check; clear and the unused code do
// no scan. The scan goes through the single read port of the ring memory,
// which is read one stamp per cycle. in_i.ready is high only between
// transactions, so the next transaction is taken in the cycle after the
// result is loaded at the earliest.
// Stalls: the result register holds a result until out_o.ready; the
// controller then waits before loading the next result, and takes no new
// input transaction until it has done so.
// Reset: counters, peak and ring bookkeeping clear at once and the peak
// window returns to 600000 ms; the ring memory needs no clearing pass.
module sliding_window_event_rate_unit import swer_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swer_in_if.sink    in_i,
  swer_cfg_if.sink   cfg_i,
  swer_out_if.source out_o
);

  swer_cmd_t    cmd;
  swer_status_t status;
  logic         in_ready;

  assign in_i.ready = in_ready;

  // Sequencing of each transaction.
  swer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Ring, counters and result register.
  swer_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_func_i (in_i.func),
    .in_time_i (in_i.time_ms),
    .in_win_i  (in_i.query_window_ms),
    .cfg_i     (cfg_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_o     (out_o)
  );

`ifndef NO_ASSERTIONS
  // Only one transaction is in progress at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while a transaction is in progress");

  // Commands that act on the ring or the result never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.exec_clear, cmd.exec_record, cmd.scan_rd,
              cmd.trunc_rd, cmd.emit}))
    else $error("overlapping datapath commands");

  // Truncation can only be reported after stamps were dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.window_truncated |-> out_o.discarded_records != '0)
    else $error("truncation reported with no dropped stamps");

  // A result is only loaded while the controller is not taking input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !in_i.ready)
    else $error("result loaded outside a transaction");
`endif

endmodule

FILE: rtl/swer_datapath.sv
// Datapath: stamp ring memory, counters, window compare and result register.
module swer_datapath import swer_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic [DATA_W-1:0] in_time_i,
  input  logic [DATA_W-1:0] in_win_i,
  swer_cfg_if.sink          cfg_i,
  input  swer_cmd_t         cmd_i,
  output swer_status_t      status_o,
  swer_out_if.source        out_o
);

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(RING_DEPTH);

  // Latched transaction and configuration.
  logic [FUNC_W-1:0] func_q;
  logic [DATA_W-1:0] time_q, win_q;
  logic [DATA_W-1:0] peak_win_q;

  // Ring and its bookkeeping.
  logic [DATA_W-1:0] ring [RING_DEPTH];
  logic [IdxW-1:0]   slot_q;
  logic [CntW-1:0]   held_q;
  logic [DATA_W-1:0] lost_q, total_q, best_time_q;
  logic [CntW-1:0]   best_cnt_q;

  // Scan state.
  logic [CntW-1:0]   scan_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_scan_q, rd_trunc_q;
  logic [CntW-1:0]   acc_q;
  logic              trunc_q;

  // Result register.
  logic                 out_valid_q;
  logic [CNT_OUT_W-1:0] out_wcount_q, out_peak_q, out_held_q;
  logic                 out_trunc_q;
  logic [DATA_W-1:0]    out_peak_time_q, out_total_q, out_lost_q;

  logic              ring_full;
  logic [DATA_W-1:0] scan_win, age;
  logic              hit;
  logic              best_upd;
  logic [CntW-1:0]   best_cnt_d, wcount_d;
  logic [CntW+CNT_OUT_W-1:0] wcount_ext, best_ext, held_ext;

  assign ring_full = (held_q == DepthCnt);

  // Latch the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      time_q <= in_time_i;
      win_q  <= in_win_i;
    end
  end

  // Configuration register; writes are always taken.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_win_q <= PEAK_WINDOW_RESET;
    end else if (cfg_i.valid) begin
      peak_win_q <= cfg_i.data;
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_record) begin
      ring[slot_q] <= time_q;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= ring[scan_q[IdxW-1:0]];
    end else if (cmd_i.trunc_rd) begin
      rd_data_q <= ring[slot_q];
    end
  end

  // Tags that say what the read data is for.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_scan_q  <= 1'b0;
      rd_trunc_q <= 1'b0;
    end else begin
      rd_scan_q  <= cmd_i.scan_rd;
      rd_trunc_q <= cmd_i.trunc_rd;
    end
  end

  // Wrap-safe age test: the age must be non-negative and below the window.
  assign scan_win = (func_q == FUNC_RECORD) ? peak_win_q : win_q;
  assign age      = time_q - rd_data_q;
  assign hit      = !age[DATA_W-1] && (age < scan_win);

  // Scan address and hit accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      acc_q   <= '0;
      trunc_q <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.load) begin
        acc_q   <= '0;
        trunc_q <= 1'b0;
      end else begin
        if (rd_scan_q && hit) begin
          acc_q <= acc_q + 1'b1;
        end
        if (rd_trunc_q && hit) begin
          trunc_q <= 1'b1;
        end
      end
    end
  end

  // Peak update only when the record count strictly grows.
  assign best_upd   = (func_q == FUNC_RECORD) && (acc_q > best_cnt_q);
  assign best_cnt_d = best_upd ? acc_q : best_cnt_q;

  // Ring bookkeeping and event counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      held_q      <= '0;
      lost_q      <= '0;
      total_q     <= '0;
      best_cnt_q  <= '0;
      best_time_q <= '0;
    end else if (cmd_i.exec_clear) begin
      slot_q      <= '0;
      held_q      <= '0;
      lost_q      <= '0;
      total_q     <= '0;
      best_cnt_q  <= '0;
      best_time_q <= '0;
    end else if (cmd_i.exec_record) begin
      slot_q <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
      if (ring_full) begin
        lost_q <= lost_q + 1'b1;
      end else begin
        held_q <= held_q + 1'b1;
      end
      if (total_q != '1) begin
        total_q <= total_q + 1'b1;
      end
    end else if (cmd_i.emit && best_upd) begin
      best_cnt_q  <= acc_q;
      best_time_q <= time_q;
    end
  end

  // Fit the internal counts to the fixed result field width.
  assign wcount_d   = ((func_q == FUNC_RECORD) || (func_q == FUNC_QUERY)) ? acc_q : '0;
  assign wcount_ext = {{CNT_OUT_W{1'b0}}, wcount_d};
  assign best_ext   = {{CNT_OUT_W{1'b0}}, best_cnt_d};
  assign held_ext   = {{CNT_OUT_W{1'b0}}, held_q};

  // Result register; a new result may load as the old one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_wcount_q    <= wcount_ext[CNT_OUT_W-1:0];
      out_trunc_q     <= (func_q == FUNC_QUERY) && trunc_q;
      out_peak_q      <= best_ext[CNT_OUT_W-1:0];
      out_peak_time_q <= best_upd ? time_q : best_time_q;
      out_total_q     <= total_q;
      out_lost_q      <= lost_q;
      out_held_q      <= held_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.window_count      = out_wcount_q;
  assign out_o.window_truncated  = out_trunc_q;
  assign out_o.peak_count        = out_peak_q;
  assign out_o.peak_time_ms      = out_peak_time_q;
  assign out_o.total_records     = out_total_q;
  assign out_o.discarded_records = out_lost_q;
  assign out_o.retained_records  = out_held_q;

  // Status towards the controller.
  always_comb begin
    status_o.func           = func_q;
    status_o.ring_empty     = (held_q == '0);
    status_o.scan_last      = ((scan_q + 1'b1) == held_q);
    status_o.trunc_possible = ring_full && (lost_q != '0);
    status_o.out_busy       = out_valid_q && !out_o.ready;
  end

endmodule

FILE: rtl/swer_ctrl.sv
// Controller: sequences one transaction through update, ring scan, truncation check and result.
module swer_ctrl import swer_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  swer_status_t status_i,
  output swer_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.scan_clr = 1'b1;
        case (status_i.func)
          FUNC_CLEAR: begin
            cmd_o.exec_clear = 1'b1;
            state_d          = S_WAIT;
          end
          FUNC_RECORD: begin
            cmd_o.exec_record = 1'b1;
            state_d           = S_SCAN;
          end
          FUNC_QUERY: begin
            state_d = status_i.ring_empty ? S_TAIL : S_SCAN;
          end
          default: begin
            state_d = S_WAIT;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = (status_i.func == FUNC_QUERY) ? S_TAIL : S_WAIT;
        end
      end
      S_TAIL: begin
        cmd_o.trunc_rd = status_i.trunc_possible;
        state_d        = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
